// ===== design/fsmc_pkg.sv =====
// Shared types and constants of the flash save memory controller.
// Used by fsmc_ctrl, fsmc_dp and flash_save_memory_controller; no dependencies.
`timescale 1ns / 1ps

package fsmc_pkg;

  localparam int OFFSET_W = 16;
  localparam int DATA_W   = 8;

  // default geometry
  localparam int BANK_BYTES_DEF   = 65536;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int NUM_BANKS_DEF    = 2;

  // reciprocal multiply shift used for constant division
  localparam int RECIP_SH = 32;

  localparam logic OP_WRITE = 1'b1;

  localparam logic [OFFSET_W-1:0] ADDR_UNLOCK_A = 16'h5555;
  localparam logic [OFFSET_W-1:0] ADDR_UNLOCK_B = 16'h2AAA;

  localparam logic [DATA_W-1:0] CMD_UNLOCK_A     = 8'hAA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK_B     = 8'h55;
  localparam logic [DATA_W-1:0] CMD_ID_ENTER     = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT      = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_ERASE_ARM    = 8'h80;
  localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_BANK_SEL     = 8'hB0;
  localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;

  localparam logic [DATA_W-1:0] ID_MFR_SINGLE = 8'hBF;
  localparam logic [DATA_W-1:0] ID_DEV_SINGLE = 8'hD4;
  localparam logic [DATA_W-1:0] ID_MFR_DUAL   = 8'hC2;
  localparam logic [DATA_W-1:0] ID_DEV_DUAL   = 8'h09;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [3:0] {
    CB_UNLOCK_A,
    CB_UNLOCK_B,
    CB_ID_ENTER,
    CB_ID_EXIT,
    CB_ERASE_ARM,
    CB_CHIP_ERASE,
    CB_PROGRAM,
    CB_BANK_SEL,
    CB_SECTOR_ERASE,
    CB_OTHER
  } cmd_byte_e;

  typedef enum logic [2:0] {
    PH_READY,
    PH_CMD1,
    PH_CMD2,
    PH_PROGRAM,
    PH_BANK
  } phase_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_ADDR1,
    S_ADDR2,
    S_ADDR3,
    S_ADDR4,
    S_EXEC,
    S_RMW,
    S_ERASE,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic prog_wr;
    logic sweep_full;
    logic sweep_sector;
    logic sweep_step;
    logic out_load;
    logic bank;
    logic id_mode;
    logic kind;
  } fsmc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic      op_write;
    logic      off_unlock_a;
    logic      off_unlock_b;
    logic      off_zero;
    cmd_byte_e cbyte;
    logic      val_lsb;
    logic      sweep_done;
  } fsmc_stat_t;

endpackage

// ===== design/fsmc_dp.sv =====
// Datapath: transfer registers, bank/sector address arithmetic, byte store, result register.
// Depends on fsmc_pkg; driven by fsmc_ctrl.
`timescale 1ns / 1ps

module fsmc_dp #(
  parameter int BANK_BYTES   = fsmc_pkg::BANK_BYTES_DEF,
  parameter int SECTOR_BYTES = fsmc_pkg::SECTOR_BYTES_DEF,
  parameter int NUM_BANKS    = fsmc_pkg::NUM_BANKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          operation_i,
  input  logic [fsmc_pkg::OFFSET_W-1:0] offset_i,
  input  logic [fsmc_pkg::DATA_W-1:0]   write_value_i,
  input  fsmc_pkg::fsmc_cmd_t           cmd_i,
  output fsmc_pkg::fsmc_stat_t          stat_o,
  output logic [fsmc_pkg::DATA_W-1:0]   read_data_o
);
  import fsmc_pkg::*;

  localparam int DEPTH = NUM_BANKS * BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PTR_W = $clog2(DEPTH + 1);
  localparam int BW    = $clog2(BANK_BYTES);
  localparam int SE_W  = $clog2(BANK_BYTES + SECTOR_BYTES + 1);

  // offset / BANK_BYTES by reciprocal; exact for 16-bit numerators
  localparam int QB_MAX = (2 ** OFFSET_W - 1) / BANK_BYTES;
  localparam int QB_W   = (QB_MAX > 0) ? $clog2(QB_MAX + 1) : 1;
  localparam int QB_MW  = RECIP_SH + QB_W;
  localparam longint unsigned RB =
      ((64'd1 << RECIP_SH) + longint'(BANK_BYTES) - 64'd1) / longint'(BANK_BYTES);
  localparam logic [QB_MW-1:0] RB_C = QB_MW'(RB);

  // in_bank / SECTOR_BYTES
  localparam int QS_MAX = (BANK_BYTES - 1) / SECTOR_BYTES;
  localparam int QS_W   = (QS_MAX > 0) ? $clog2(QS_MAX + 1) : 1;
  localparam int QS_MW  = RECIP_SH + QS_W;
  localparam longint unsigned RS =
      ((64'd1 << RECIP_SH) + longint'(SECTOR_BYTES) - 64'd1) / longint'(SECTOR_BYTES);
  localparam logic [QS_MW-1:0] RS_C = QS_MW'(RS);

  logic                op_q;
  logic [OFFSET_W-1:0] off_q;
  logic [DATA_W-1:0]   val_q;
  logic [QB_W-1:0]     qb_q, qb_d;
  logic [BW-1:0]       inb_q, inb_d;
  logic [QS_W-1:0]     qs_q, qs_d;
  logic [BW-1:0]       ss_q, ss_d;
  logic [QB_MW-1:0]    prod_b;
  logic [QS_MW-1:0]    prod_s;
  logic [OFFSET_W-1:0] bank_floor;
  logic [OFFSET_W-1:0] inb_full;
  logic [AW-1:0]       addr;
  logic [PTR_W-1:0]    base;
  logic [SE_W-1:0]     sec_sum;
  logic [SE_W-1:0]     sec_end;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [PTR_W-1:0]    end_q, end_d;
  logic [DATA_W-1:0]   store_q [DEPTH];
  logic [DATA_W-1:0]   rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [DATA_W-1:0]   result;
  logic [DATA_W-1:0]   rd_data_q;
  cmd_byte_e           cbyte;

  // address pipeline, each stage re-evaluated every cycle from the held transfer
  assign prod_b     = QB_MW'(off_q) * RB_C;
  assign qb_d       = prod_b[RECIP_SH +: QB_W];
  assign bank_floor = OFFSET_W'(qb_q) * OFFSET_W'(BANK_BYTES);
  assign inb_full   = off_q - bank_floor;
  assign inb_d      = inb_full[BW-1:0];
  assign prod_s     = QS_MW'(inb_q) * RS_C;
  assign qs_d       = prod_s[RECIP_SH +: QS_W];
  assign ss_d       = BW'(qs_q) * BW'(SECTOR_BYTES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      off_q <= offset_i;
      val_q <= write_value_i;
    end
    qb_q  <= qb_d;
    inb_q <= inb_d;
    qs_q  <= qs_d;
    ss_q  <= ss_d;
  end

  assign addr = AW'(inb_q) + (cmd_i.bank ? AW'(BANK_BYTES) : AW'(0));
  assign base = cmd_i.bank ? PTR_W'(BANK_BYTES) : PTR_W'(0);

  // sector clipped to the bank end
  assign sec_sum = SE_W'(ss_q) + SE_W'(SECTOR_BYTES);
  assign sec_end = (sec_sum > SE_W'(BANK_BYTES)) ? SE_W'(BANK_BYTES) : sec_sum;

  always_comb begin
    ptr_d = ptr_q;
    end_d = end_q;
    if (cmd_i.sweep_full) begin
      ptr_d = '0;
      end_d = PTR_W'(DEPTH);
    end else if (cmd_i.sweep_sector) begin
      ptr_d = base + PTR_W'(ss_q);
      end_d = base + PTR_W'(sec_end);
    end else if (cmd_i.sweep_step) begin
      ptr_d = ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    end_q <= end_d;
  end

  assign mem_we    = cmd_i.sweep_step | cmd_i.prog_wr;
  assign mem_waddr = cmd_i.sweep_step ? ptr_q[AW-1:0] : addr;
  assign mem_wdata = cmd_i.sweep_step ? ERASED_BYTE : (rdata_q & val_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= store_q[addr];
    end
  end

  always_comb begin
    unique case (val_q)
      CMD_UNLOCK_A:     cbyte = CB_UNLOCK_A;
      CMD_UNLOCK_B:     cbyte = CB_UNLOCK_B;
      CMD_ID_ENTER:     cbyte = CB_ID_ENTER;
      CMD_ID_EXIT:      cbyte = CB_ID_EXIT;
      CMD_ERASE_ARM:    cbyte = CB_ERASE_ARM;
      CMD_CHIP_ERASE:   cbyte = CB_CHIP_ERASE;
      CMD_PROGRAM:      cbyte = CB_PROGRAM;
      CMD_BANK_SEL:     cbyte = CB_BANK_SEL;
      CMD_SECTOR_ERASE: cbyte = CB_SECTOR_ERASE;
      default:          cbyte = CB_OTHER;
    endcase
  end

  assign stat_o.op_write     = (op_q == OP_WRITE);
  assign stat_o.off_unlock_a = (off_q == ADDR_UNLOCK_A);
  assign stat_o.off_unlock_b = (off_q == ADDR_UNLOCK_B);
  assign stat_o.off_zero     = (off_q == '0);
  assign stat_o.cbyte        = cbyte;
  assign stat_o.val_lsb      = val_q[0];
  assign stat_o.sweep_done   = (ptr_q == end_q);

  always_comb begin
    priority if (op_q == OP_WRITE) begin
      result = '0;
    end else if (cmd_i.id_mode && off_q == OFFSET_W'(0)) begin
      result = cmd_i.kind ? ID_MFR_DUAL : ID_MFR_SINGLE;
    end else if (cmd_i.id_mode && off_q == OFFSET_W'(1)) begin
      result = cmd_i.kind ? ID_DEV_DUAL : ID_DEV_SINGLE;
    end else begin
      result = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rd_data_q <= result;
    end
  end

  assign read_data_o = rd_data_q;

endmodule

// ===== design/fsmc_ctrl.sv =====
// Controller: sequencing state machine plus flash command state (unlock phase, ID mode,
// erase arm, bank select), device kind register and result valid. Depends on fsmc_pkg.
`timescale 1ns / 1ps

module fsmc_ctrl #(
  parameter int NUM_BANKS = fsmc_pkg::NUM_BANKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_device_kind_i,
  input  fsmc_pkg::fsmc_stat_t stat_i,
  output fsmc_pkg::fsmc_cmd_t  cmd_o
);
  import fsmc_pkg::*;

  localparam logic DUAL = (NUM_BANKS > 1);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   id_mode_q, id_mode_d;
  logic   armed_q, armed_d;
  logic   bank_q, bank_d;
  logic   kind_q;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      phase_q     <= PH_READY;
      id_mode_q   <= 1'b0;
      armed_q     <= 1'b0;
      bank_q      <= 1'b0;
      kind_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      id_mode_q   <= id_mode_d;
      armed_q     <= armed_d;
      bank_q      <= bank_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        kind_q <= cfg_device_kind_i;
      end
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    id_mode_d   = id_mode_q;
    armed_d     = armed_q;
    bank_d      = bank_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o              = '0;
    cmd_o.bank         = DUAL & kind_q & bank_q;
    cmd_o.id_mode      = id_mode_q;
    cmd_o.kind         = kind_q;

    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_full = 1'b1;
        state_d          = S_CLEAR;
      end
      S_CLEAR: begin
        if (stat_i.sweep_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.sweep_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_ADDR1;
        end
      end
      S_ADDR1: state_d = S_ADDR2;
      S_ADDR2: state_d = S_ADDR3;
      S_ADDR3: state_d = S_ADDR4;
      S_ADDR4: state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_RESP;
        priority if (!stat_i.op_write) begin
          cmd_o.mem_rd = 1'b1;
        end else if (phase_q == PH_PROGRAM) begin
          cmd_o.mem_rd = 1'b1;
          phase_d      = PH_READY;
          state_d      = S_RMW;
        end else if (phase_q == PH_BANK) begin
          if (stat_i.off_zero) begin
            bank_d = stat_i.val_lsb;
          end
          phase_d = PH_READY;
        end else if (stat_i.off_unlock_a && stat_i.cbyte == CB_UNLOCK_A) begin
          // unlock restarts from the ready or either command phase, not from program or bank
          phase_d = PH_CMD1;
        end else if (phase_q == PH_CMD1 && stat_i.off_unlock_b &&
                     stat_i.cbyte == CB_UNLOCK_B) begin
          phase_d = PH_CMD2;
        end else if (phase_q == PH_CMD2) begin
          phase_d = PH_READY;
          if (stat_i.off_unlock_a) begin
            unique case (stat_i.cbyte)
              CB_ID_ENTER:  id_mode_d = 1'b1;
              CB_ID_EXIT:   id_mode_d = 1'b0;
              CB_ERASE_ARM: armed_d   = 1'b1;
              CB_CHIP_ERASE: begin
                if (armed_q) begin
                  cmd_o.sweep_full = 1'b1;
                  armed_d          = 1'b0;
                  state_d          = S_ERASE;
                end
              end
              CB_PROGRAM: phase_d = PH_PROGRAM;
              CB_BANK_SEL: begin
                if (kind_q) begin
                  phase_d = PH_BANK;
                end
              end
              default: ;
            endcase
          end else if (stat_i.cbyte == CB_SECTOR_ERASE && armed_q) begin
            cmd_o.sweep_sector = 1'b1;
            armed_d            = 1'b0;
            state_d            = S_ERASE;
          end
        end else begin
          phase_d = PH_READY;
        end
      end
      S_RMW: begin
        cmd_o.prog_wr = 1'b1;
        state_d       = S_RESP;
      end
      S_ERASE: begin
        if (stat_i.sweep_done) begin
          state_d = S_RESP;
        end else begin
          cmd_o.sweep_step = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

// ===== design/flash_save_memory_controller.sv =====
// Top level of the flash save memory controller: joins fsmc_ctrl and fsmc_dp.
// Depends on fsmc_pkg, fsmc_ctrl, fsmc_dp.
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o  | operation_i, offset_i, write_value_i
//  out     | out_valid_o / out_ready_i| read_data_o
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_device_kind_i
//
// One transfer at a time: a read or plain write is captured, passes the four-stage
// constant-divide address pipeline and the execute state with its registered store read,
// and its result is loaded in the response state before the next transfer is taken; a
// program write adds a read-modify-write state. An erase adds a sweep that writes one byte
// per cycle through the single store write port until the end of the sector is reached
// (SECTOR_BYTES, clipped to the bank end) or of the chip (NUM_BANKS*BANK_BYTES for chip).
// After reset the store is cleared by a full sweep of NUM_BANKS*BANK_BYTES; no input is taken
// meanwhile. A result left waiting holds the next item in its response state, so input
// stalls until the waiting transfer completes.
`timescale 1ns / 1ps

module flash_save_memory_controller #(
  parameter int BANK_BYTES   = fsmc_pkg::BANK_BYTES_DEF,
  parameter int SECTOR_BYTES = fsmc_pkg::SECTOR_BYTES_DEF,
  parameter int NUM_BANKS    = fsmc_pkg::NUM_BANKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [fsmc_pkg::OFFSET_W-1:0] offset_i,
  input  logic [fsmc_pkg::DATA_W-1:0]   write_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsmc_pkg::DATA_W-1:0]   read_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_device_kind_i
);
  import fsmc_pkg::*;

  fsmc_cmd_t  cmd;
  fsmc_stat_t stat;

  fsmc_ctrl #(
    .NUM_BANKS(NUM_BANKS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_device_kind_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fsmc_dp #(
    .BANK_BYTES  (BANK_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .NUM_BANKS   (NUM_BANKS)
  ) u_dp (
    .clk_i,
    .operation_i,
    .offset_i,
    .write_value_i,
    .cmd_i  (cmd),
    .stat_o (stat),
    .read_data_o
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for flash_save_memory_controller: bus accesses through the
// command sequences, with results checked against a byte-level model of the flash chip.
// Depends on fsmc_pkg and the flash_save_memory_controller RTL.
`timescale 1ns / 1ps

module tb_top;
  import fsmc_pkg::*;

  localparam logic OP_READ   = ~OP_WRITE;
  localparam int   BANK_SZ   = BANK_BYTES_DEF;
  localparam int   SECTOR_SZ = SECTOR_BYTES_DEF;
  localparam int   IMG_BYTES = NUM_BANKS_DEF * BANK_BYTES_DEF;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                operation_i       = 1'b0;
  logic [OFFSET_W-1:0] offset_i          = '0;
  logic [DATA_W-1:0]   write_value_i     = '0;
  logic                out_ready_i       = 1'b0;
  logic                cfg_valid_i       = 1'b0;
  logic                cfg_device_kind_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [DATA_W-1:0]   read_data_o;
  logic                cfg_ready_o;

  flash_save_memory_controller u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .offset_i          (offset_i),
    .write_value_i     (write_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_device_kind_i (cfg_device_kind_i)
  );

  always #1 clk_i = ~clk_i;

  // chip image and command state
  logic [DATA_W-1:0] flash_img [IMG_BYTES];
  phase_e            chip_phase;
  logic              chip_kind;
  logic              chip_id_on;
  logic              chip_erase_armed;
  logic              chip_bank;

  logic [DATA_W-1:0]   read_data_due [$];
  logic [OFFSET_W-1:0] hot_offsets [16];
  int                  idle_pct           = 18;
  int                  accesses_sent      = 0;
  int                  mismatches         = 0;
  int                  results_seen       = 0;
  int                  sector_erases_left = 40;
  int                  chip_erases_left   = 2;
  logic [DATA_W-1:0]   due_byte;

  function automatic void chip_reset();
    for (int i = 0; i < IMG_BYTES; i++) flash_img[i] = ERASED_BYTE;
    chip_phase       = PH_READY;
    chip_kind        = 1'b0;
    chip_id_on       = 1'b0;
    chip_erase_armed = 1'b0;
    chip_bank        = 1'b0;
  endfunction

  function automatic int chip_addr(logic [OFFSET_W-1:0] off);
    return ((chip_kind && chip_bank) ? BANK_SZ : 0) + int'(off);
  endfunction

  // one bus access against the chip image; data is what the bus returns
  function automatic void flash_access(input logic op, input logic [OFFSET_W-1:0] off,
                                       input logic [DATA_W-1:0] val,
                                       output logic [DATA_W-1:0] data);
    phase_e next_phase;
    int     first;
    int     last;
    data = '0;
    if (op == OP_WRITE) begin
      if (chip_phase == PH_PROGRAM) begin
        flash_img[chip_addr(off)] &= val;
        chip_phase = PH_READY;
      end else if (chip_phase == PH_BANK) begin
        if (off == '0) chip_bank = val[0];
        chip_phase = PH_READY;
      end else if (off == ADDR_UNLOCK_A && val == CMD_UNLOCK_A) begin
        chip_phase = PH_CMD1;
      end else if (chip_phase == PH_CMD1 && off == ADDR_UNLOCK_B && val == CMD_UNLOCK_B) begin
        chip_phase = PH_CMD2;
      end else begin
        next_phase = PH_READY;
        if (chip_phase == PH_CMD2) begin
          if (off == ADDR_UNLOCK_A) begin
            case (val)
              CMD_ID_ENTER:  chip_id_on = 1'b1;
              CMD_ID_EXIT:   chip_id_on = 1'b0;
              CMD_ERASE_ARM: chip_erase_armed = 1'b1;
              CMD_CHIP_ERASE: begin
                if (chip_erase_armed) begin
                  for (int i = 0; i < IMG_BYTES; i++) flash_img[i] = ERASED_BYTE;
                  chip_erase_armed = 1'b0;
                end
              end
              CMD_PROGRAM:  next_phase = PH_PROGRAM;
              CMD_BANK_SEL: if (chip_kind) next_phase = PH_BANK;
              default: ;
            endcase
          end else if (val == CMD_SECTOR_ERASE && chip_erase_armed) begin
            first = int'(off) - (int'(off) % SECTOR_SZ);
            last  = (first + SECTOR_SZ > BANK_SZ) ? BANK_SZ : first + SECTOR_SZ;
            for (int i = first; i < last; i++)
              flash_img[chip_addr(OFFSET_W'(i))] = ERASED_BYTE;
            chip_erase_armed = 1'b0;
          end
        end
        chip_phase = next_phase;
      end
    end else if (chip_id_on && off == 16'd0) begin
      data = chip_kind ? ID_MFR_DUAL : ID_MFR_SINGLE;
    end else if (chip_id_on && off == 16'd1) begin
      data = chip_kind ? ID_DEV_DUAL : ID_DEV_SINGLE;
    end else begin
      data = flash_img[chip_addr(off)];
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH t=%0t result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  // result side: random back-pressure and in-order compare
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (read_data_due.size() == 0) begin
        report_mismatch($sformatf("unexpected read_data %02h", read_data_o));
      end else begin
        due_byte = read_data_due.pop_front();
        if (read_data_o !== due_byte)
          report_mismatch($sformatf("read_data %02h, want %02h", read_data_o, due_byte));
      end
      results_seen++;
    end
  end

  task automatic send_access(input logic op, input logic [OFFSET_W-1:0] off,
                             input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] data;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    offset_i      <= off;
    write_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    flash_access(op, off, val, data);
    read_data_due = {read_data_due, data};
    accesses_sent++;
  endtask

  task automatic read_byte(input logic [OFFSET_W-1:0] off);
    send_access(OP_READ, off, DATA_W'($urandom_range(255)));
  endtask

  task automatic write_byte(input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] val);
    send_access(OP_WRITE, off, val);
  endtask

  // unlock pair followed by the command byte
  task automatic issue_command(input logic [DATA_W-1:0] cmd, input logic [OFFSET_W-1:0] off);
    write_byte(ADDR_UNLOCK_A, CMD_UNLOCK_A);
    write_byte(ADDR_UNLOCK_B, CMD_UNLOCK_B);
    write_byte(off, cmd);
  endtask

  // always waits on the clock before returning so valid is never lowered and raised in one step
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (read_data_due.size() != 0);
  endtask

  task automatic set_device_kind(input logic kind);
    cfg_valid_i       <= 1'b1;
    cfg_device_kind_i <= kind;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    chip_kind = kind;
  endtask

  function automatic logic [OFFSET_W-1:0] any_offset();
    if ($urandom_range(1)) return hot_offsets[$urandom_range(15)];
    return OFFSET_W'($urandom_range(65535));
  endfunction

  task automatic test_id_mode();
    issue_command(CMD_ID_ENTER, ADDR_UNLOCK_A);
    read_byte(16'h0000);
    read_byte(16'h0001);
    read_byte(16'hFFFF);
    issue_command(CMD_ID_EXIT, ADDR_UNLOCK_A);
    read_byte(16'h0000);
  endtask

  task automatic test_program();
    issue_command(CMD_PROGRAM, ADDR_UNLOCK_A);
    write_byte(16'hFFFF, 8'h00);
    read_byte(16'hFFFF);
  endtask

  task automatic test_erase();
    issue_command(CMD_CHIP_ERASE, ADDR_UNLOCK_A);  // not armed: no effect
    read_byte(16'hFFFF);
    issue_command(CMD_ERASE_ARM, ADDR_UNLOCK_A);
    issue_command(CMD_SECTOR_ERASE, 16'hF0F0);
    read_byte(16'hFFFF);
  endtask

  task automatic test_bank_select();
    // single bank kind ignores the bank command; the data write is then a plain write
    issue_command(CMD_BANK_SEL, ADDR_UNLOCK_A);
    write_byte(16'h0000, 8'h01);
    wait_drained();
    set_device_kind(1'b1);
    issue_command(CMD_BANK_SEL, ADDR_UNLOCK_A);
    write_byte(16'h0000, 8'h01);
    read_byte(16'hFFFF);
  endtask

  task automatic random_ops(input int count);
    int                  stop_at;
    int                  pick;
    logic [DATA_W-1:0]   val;
    logic [OFFSET_W-1:0] off;
    stop_at = accesses_sent + count;
    while (accesses_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        read_byte(any_offset());
      end else if (pick < 48) begin
        issue_command(CMD_PROGRAM, ADDR_UNLOCK_A);
        write_byte(any_offset(), DATA_W'($urandom_range(255)));
      end else if (pick < 53) begin
        issue_command(chip_id_on ? CMD_ID_EXIT : CMD_ID_ENTER, ADDR_UNLOCK_A);
      end else if (pick < 58) begin
        issue_command(CMD_ERASE_ARM, ADDR_UNLOCK_A);
      end else if (pick < 64) begin
        // erases are slow: keep their number bounded
        if (!chip_erase_armed && sector_erases_left > 0 && $urandom_range(1))
          issue_command(CMD_ERASE_ARM, ADDR_UNLOCK_A);
        if (chip_erase_armed && sector_erases_left == 0) begin
          issue_command(CMD_ERASE_ARM, ADDR_UNLOCK_A);
        end else begin
          if (chip_erase_armed) sector_erases_left--;
          issue_command(CMD_SECTOR_ERASE, any_offset());
        end
      end else if (pick < 65) begin
        if (!chip_erase_armed && chip_erases_left > 0)
          issue_command(CMD_ERASE_ARM, ADDR_UNLOCK_A);
        if (chip_erase_armed && chip_erases_left == 0) begin
          issue_command(CMD_ERASE_ARM, ADDR_UNLOCK_A);
        end else begin
          if (chip_erase_armed) chip_erases_left--;
          issue_command(CMD_CHIP_ERASE, ADDR_UNLOCK_A);
        end
      end else if (pick < 73) begin
        issue_command(CMD_BANK_SEL, ADDR_UNLOCK_A);
        write_byte(($urandom_range(3) == 0) ? any_offset() : 16'h0000,
                   DATA_W'($urandom_range(255)));
      end else if (pick < 83) begin
        write_byte(ADDR_UNLOCK_A, CMD_UNLOCK_A);
        case ($urandom_range(3))
          0: begin
            val = DATA_W'($urandom_range(255));
            if (val == CMD_UNLOCK_B) val = ~val;
            write_byte(ADDR_UNLOCK_B, val);
          end
          1: begin
            off = OFFSET_W'($urandom_range(65535));
            if (off == ADDR_UNLOCK_B) off = ~off;
            write_byte(off, CMD_UNLOCK_B);
          end
          2: begin
            // reads between unlock writes leave the sequence intact
            read_byte(any_offset());
            write_byte(ADDR_UNLOCK_B, CMD_UNLOCK_B);
            read_byte(any_offset());
            write_byte(ADDR_UNLOCK_A, chip_id_on ? CMD_ID_EXIT : CMD_ID_ENTER);
          end
          default: begin
            // restart of the unlock from its first write
            issue_command(chip_id_on ? CMD_ID_EXIT : CMD_ID_ENTER, ADDR_UNLOCK_A);
          end
        endcase
      end else if (pick < 89) begin
        do val = DATA_W'($urandom_range(255));
        while (val inside {CMD_ID_ENTER, CMD_ID_EXIT, CMD_ERASE_ARM, CMD_CHIP_ERASE,
                           CMD_PROGRAM, CMD_BANK_SEL});
        issue_command(val, ADDR_UNLOCK_A);
      end else begin
        write_byte(any_offset(), DATA_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random_traffic();
    random_ops(185);
    wait_drained();  // sender holds off until the pipeline is empty
    random_ops(185);
    wait_drained();
    set_device_kind(1'b0);
    idle_pct = 0;
    random_ops(370);
    wait_drained();
    idle_pct = 18;
    set_device_kind(1'b1);
    random_ops(370);
    wait_drained();
    set_device_kind(1'b0);
    random_ops(370);
  endtask

  initial begin
    chip_reset();
    hot_offsets[0] = 16'h0000;
    hot_offsets[1] = 16'h0001;
    hot_offsets[2] = 16'hFFFF;
    hot_offsets[3] = ADDR_UNLOCK_A;
    hot_offsets[4] = ADDR_UNLOCK_B;
    hot_offsets[5] = 16'h0FFF;
    hot_offsets[6] = 16'h1000;
    for (int i = 7; i < 16; i++) hot_offsets[i] = OFFSET_W'($urandom_range(65535));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_device_kind(1'b0);
    test_id_mode();
    test_program();
    test_erase();
    test_bank_select();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && read_data_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // covers the clearing pass, two full chip erases and the bounded sector erases
  initial begin
    #10_000_000;
    $display("TIMEOUT with %0d results outstanding", read_data_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
